// File: hdl/alr_pkg.sv
`default_nettype none
package alr_pkg;

  // Field and state widths.
  localparam int COORD_W = 24;
  localparam int COORD_F = 8;
  localparam int SLOPE_F = 16;
  localparam int COV_F   = 8;
  localparam int PIX_W   = 16;
  localparam int COV_W   = COV_F + 1;
  localparam int COL_W   = PIX_W + 2;
  localparam int ICPT_W  = 32;
  localparam int SLOPE_W = SLOPE_F + 2;
  localparam int QUO_W   = SLOPE_F + 1;
  localparam int GAP_W   = COORD_F + 2;
  localparam int MUL_AW  = SLOPE_W + 1;
  localparam int MUL_BW  = GAP_W + 1;
  localparam int MUL_PW  = MUL_AW + MUL_BW;

  // Commands carried by an input word.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SWAP = 9'b000000010,
    ST_SORT = 9'b000000100,
    ST_PREP = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_EPM  = 9'b000100000,
    ST_EPA  = 9'b001000000,
    ST_EMIT = 9'b010000000,
    ST_STEP = 9'b100000000
  } state_t;

  // Divider status towards the sequencer.
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_res_t;

  // Major coordinate rounded to the nearest pixel, ties away from zero.
  function automatic logic signed [COL_W-1:0] round_coord(input logic signed [COORD_W-1:0] v);
    logic [COORD_W:0] mag;
    logic [COORD_W:0] sum;
    logic [COL_W-1:0] s;
    mag = v[COORD_W-1] ? ((~{v[COORD_W-1], v}) + (COORD_W+1)'(1)) : {v[COORD_W-1], v};
    sum = mag + (COORD_W+1)'(1 << (COORD_F - 1));
    s   = COL_W'(sum >> COORD_F);
    return v[COORD_W-1] ? COL_W'(-s) : s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/alr_if.sv
`default_nettype none
// Command words into the rasteriser.
interface alr_req_if;
  import alr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic signed [COORD_W-1:0]  start_x;
  logic signed [COORD_W-1:0]  start_y;
  logic signed [COORD_W-1:0]  end_x;
  logic signed [COORD_W-1:0]  end_y;
  modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

// Pixel words out of the rasteriser.
interface alr_res_if;
  import alr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PIX_W-1:0]  pixel_x;
  logic signed [PIX_W-1:0]  pixel_y;
  logic [COV_W-1:0]         coverage;
  logic                     last;
  logic                     done_res;
  modport source (output valid, pixel_x, pixel_y, coverage, last, done_res, input ready);
  modport sink (input valid, pixel_x, pixel_y, coverage, last, done_res, output ready);
endinterface
`default_nettype wire

// File: hdl/alr_div.sv
`default_nettype none
// Restoring divider for the rounded gradient: (2*num*2^16 + den) / (2*den).
// One quotient bit per cycle; the quotient is known to stay below 2^17.
module alr_div import alr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [COORD_W-1:0] num,
  input  logic [COORD_W-1:0] den,
  output div_res_t           res
);

  localparam int NUM_W = COORD_W + QUO_W + 1;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [COORD_W:0]   rem;
  logic [COORD_W:0]   dvs;
  logic [QUO_W-1:0]   nlow;
  logic [QUO_W-1:0]   quo;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [NUM_W-1:0]   nsum;
  logic [COORD_W+1:0] trial;
  logic               fits;

  // Dividend and one trial subtraction.
  assign nsum  = {1'b0, num, QUO_W'(0)} + NUM_W'(den);
  assign trial = {rem, nlow[QUO_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem  <= nsum[NUM_W-1:QUO_W];
        nlow <= nsum[QUO_W-1:0];
        dvs  <= {den, 1'b0};
        cnt  <= CNT_W'(QUO_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? (COORD_W+1)'(trial - {1'b0, dvs}) : trial[COORD_W:0];
        nlow <= {nlow[QUO_W-2:0], 1'b0};
        quo  <= {quo[QUO_W-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quo  = quo;

endmodule
`default_nettype wire

// File: hdl/antialiased_line_raster_core.sv
//  channel | dir | words
//  req     | in  | cmd, start_x, start_y, end_x, end_y (valid/ready)
//  res     | out | pixel_x, pixel_y, coverage, last, done_res (valid/ready)
//
// A start word passes through the accepting cycle, the swap, sort and prep set-up states,
// the one-bit-per-cycle gradient divider, the EPM and EPA states for each endpoint on
// the shared multiplier, then the pixel words; coincident endpoints skip the divider.
// A step word emits two pixel words. req.ready is high only while the sequencer is idle;
// the last pixel word waits in the output register while the next command is taken.
// A stalled res holds its word and the sequencer; rst is synchronous and clears control.
`default_nettype none
module antialiased_line_raster_core import alr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  alr_req_if.sink     req,
  alr_res_if.source   res
);

  state_t                    state;
  logic signed [COORD_W-1:0] ax0, ay0, ax1, ay1;
  logic                      steep_flag;
  logic                      dy_neg;
  logic signed [SLOPE_W-1:0] slope;
  logic                      ep;
  logic [1:0]                idx;
  logic signed [COL_W-1:0]   xe0, xe1;
  logic [ICPT_W-1:0]         ye0, ye1;
  logic [ICPT_W-1:0]         intercept;
  logic signed [COL_W-1:0]   current_column, stop_column;
  logic                      line_active;
  logic signed [MUL_PW-1:0]  prod;

  logic                      out_valid;
  logic [PIX_W-1:0]          out_x, out_y;
  logic [COV_W-1:0]          out_cov;
  logic                      out_last, out_done;

  logic                      div_go;
  div_res_t                  div_res;

  // Set-up arithmetic.
  logic signed [COORD_W:0]   dxs, dys;
  logic [COORD_W:0]          adx, ady;
  logic                      steep;
  logic [COORD_W-1:0]        dx_u, dy_abs;

  // Shared multiplier.
  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [MUL_BW-1:0]  mul_b;
  logic signed [MUL_PW-1:0]  mul_p;

  // Endpoint and pixel selection.
  logic signed [COL_W-1:0]   xe_ep;
  logic signed [COORD_W-1:0] v_ep, y_ep;
  logic signed [COORD_W+1:0] off_ep;
  logic [ICPT_W-1:0]         ye_new;
  logic [ICPT_W-1:0]         ye_s;
  logic [SLOPE_F:0]          cov_a;
  logic [GAP_W-1:0]          gap;
  logic [MUL_PW-1:0]         cov_raw;
  logic [COV_W-1:0]          cov_end;
  logic [COV_F-1:0]          fc;
  logic signed [COL_W-1:0]   col_next;
  logic                      step_more;
  logic                      load_ok;
  logic                      load_word;
  logic [COL_W-1:0]          major;
  logic [PIX_W-1:0]          minor;
  logic [COV_W-1:0]          cov_sel;

  alr_div u_div (
    .clk (clk),
    .rst (rst),
    .go  (div_go),
    .num (dy_abs),
    .den (dx_u),
    .res (div_res)
  );

  assign req.ready = (state == ST_IDLE);
  assign load_ok   = !out_valid || res.ready;
  assign load_word = ((state == ST_EMIT) || (state == ST_STEP)) && load_ok;
  assign div_go    = (state == ST_PREP) && (dx_u != '0);

  // Steepness and gradient operands.
  always_comb begin
    dxs    = {ax1[COORD_W-1], ax1} - {ax0[COORD_W-1], ax0};
    dys    = {ay1[COORD_W-1], ay1} - {ay0[COORD_W-1], ay0};
    adx    = dxs[COORD_W] ? (COORD_W+1)'(-dxs) : dxs;
    ady    = dys[COORD_W] ? (COORD_W+1)'(-dys) : dys;
    steep  = adx < ady;
    dx_u   = dxs[COORD_W-1:0];
    dy_abs = ady[COORD_W-1:0];
  end

  // Endpoint offset from its rounded column.
  always_comb begin
    xe_ep  = ep ? xe1 : xe0;
    v_ep   = ep ? ax1 : ax0;
    y_ep   = ep ? ay1 : ay0;
    off_ep = {xe_ep, COORD_F'(0)} - (COORD_W+2)'(v_ep);
    ye_new = {y_ep, COORD_F'(0)} + ICPT_W'(prod >>> COORD_F);
  end

  // Endpoint coverage operands for the word being emitted.
  always_comb begin
    ye_s  = idx[1] ? ye1 : ye0;
    cov_a = idx[0] ? {1'b0, ye_s[SLOPE_F-1:0]}
                   : (SLOPE_F+1)'(1 << SLOPE_F) - {1'b0, ye_s[SLOPE_F-1:0]};
    gap   = idx[1] ? {ax1[COORD_F-1:0], 1'b1}
                   : GAP_W'(1 << (COORD_F + 1)) - {ax0[COORD_F-1:0], 1'b1};
  end

  // One multiplier serves the endpoint intercepts and the endpoint coverage.
  always_comb begin
    if (state == ST_EPM) begin
      mul_a = MUL_AW'(slope);
      mul_b = MUL_BW'(off_ep);
    end else begin
      mul_a = MUL_AW'(cov_a);
      mul_b = MUL_BW'(gap);
    end
    mul_p   = mul_a * mul_b;
    cov_raw = mul_p >> (SLOPE_F + COORD_F + 1 - COV_F);
    cov_end = (cov_raw > MUL_PW'(1 << COV_F)) ? COV_W'(1 << COV_F) : COV_W'(cov_raw);
  end

  // Interior column values.
  always_comb begin
    fc        = intercept[SLOPE_F-1 -: COV_F];
    col_next  = current_column + COL_W'(1);
    step_more = col_next < stop_column;
  end

  // Pixel word content.
  always_comb begin
    if (state == ST_STEP) begin
      major   = current_column;
      minor   = intercept[ICPT_W-1:SLOPE_F] + PIX_W'(idx[0]);
      cov_sel = idx[0] ? COV_W'(fc) : COV_W'(1 << COV_F) - COV_W'(fc);
    end else begin
      major   = idx[1] ? xe1 : xe0;
      minor   = ye_s[ICPT_W-1:SLOPE_F] + PIX_W'(idx[0]);
      cov_sel = cov_end;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      steep_flag     <= 1'b0;
      line_active    <= 1'b0;
      current_column <= '0;
      stop_column    <= '0;
      intercept      <= '0;
      slope          <= '0;
      ep             <= 1'b0;
      idx            <= '0;
      out_valid      <= 1'b0;
    end else begin
      // The output register empties when its word is taken and nothing replaces it.
      if (out_valid && res.ready && !load_word) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            if (req.cmd == CMD_START) begin
              ax0   <= req.start_x;
              ay0   <= req.start_y;
              ax1   <= req.end_x;
              ay1   <= req.end_y;
              state <= ST_SWAP;
            end else if (line_active) begin
              idx   <= '0;
              state <= ST_STEP;
            end
          end
        end
        ST_SWAP: begin
          steep_flag <= steep;
          if (steep) begin
            ax0 <= ay0;
            ay0 <= ax0;
            ax1 <= ay1;
            ay1 <= ax1;
          end
          state <= ST_SORT;
        end
        ST_SORT: begin
          if (ax1 < ax0) begin
            ax0 <= ax1;
            ay0 <= ay1;
            ax1 <= ax0;
            ay1 <= ay0;
          end
          state <= ST_PREP;
        end
        ST_PREP: begin
          dy_neg <= dys[COORD_W];
          xe0    <= round_coord(ax0);
          xe1    <= round_coord(ax1);
          ep     <= 1'b0;
          if (dx_u == '0) begin
            slope <= SLOPE_W'(1 << SLOPE_F);
            state <= ST_EPM;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            slope <= dy_neg ? SLOPE_W'(-{1'b0, div_res.quo}) : SLOPE_W'({1'b0, div_res.quo});
            state <= ST_EPM;
          end
        end
        ST_EPM: begin
          prod  <= mul_p;
          state <= ST_EPA;
        end
        ST_EPA: begin
          if (!ep) begin
            ye0   <= ye_new;
            ep    <= 1'b1;
            state <= ST_EPM;
          end else begin
            ye1            <= ye_new;
            intercept      <= ye0 + ICPT_W'(slope);
            current_column <= xe0 + COL_W'(1);
            stop_column    <= xe1;
            line_active    <= (xe0 + COL_W'(1)) < xe1;
            idx            <= '0;
            state          <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load_ok) begin
            out_valid <= 1'b1;
            out_x     <= steep_flag ? minor : major[PIX_W-1:0];
            out_y     <= steep_flag ? major[PIX_W-1:0] : minor;
            out_cov   <= cov_sel;
            out_last  <= (idx == 2'd3);
            out_done  <= !line_active;
            idx       <= idx + 2'd1;
            if (idx == 2'd3) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_STEP: begin
          if (load_ok) begin
            out_valid <= 1'b1;
            out_x     <= steep_flag ? minor : major[PIX_W-1:0];
            out_y     <= steep_flag ? major[PIX_W-1:0] : minor;
            out_cov   <= cov_sel;
            out_last  <= idx[0];
            out_done  <= !step_more;
            idx       <= idx + 2'd1;
            if (idx[0]) begin
              intercept      <= intercept + ICPT_W'(slope);
              current_column <= col_next;
              line_active    <= step_more;
              state          <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res.valid    = out_valid;
  assign res.pixel_x  = out_x;
  assign res.pixel_y  = out_y;
  assign res.coverage = out_cov;
  assign res.last     = out_last;
  assign res.done_res = out_done;

endmodule
`default_nettype wire

// File: hdl/alr_check.sv
`default_nettype none
module alr_check import alr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             req_cmd,
  input logic             res_valid,
  input logic             res_ready,
  input logic [COV_W-1:0] res_cov,
  input logic             res_last,
  input logic             res_done
);

  // A stalled pixel word is held.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_cov) && $stable(res_last))
    else $error("pixel word changed while stalled");

  // A start word always keeps the block busy for the following cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == CMD_START |=> !req_ready)
    else $error("ready after start word");

  // Coverage never exceeds full weight.
  a_cov_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_cov <= COV_W'(1 << COV_F))
    else $error("coverage above full weight");

  // Words of one command follow without a gap and share their done flag.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=> res_valid && res_done == $past(res_done))
    else $error("gap or done change inside a command's words");

endmodule

bind antialiased_line_raster_core alr_check u_alr_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_cmd   (req.cmd),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_cov   (res.coverage),
  .res_last  (res.last),
  .res_done  (res.done_res)
);
`default_nettype wire
